>>> design/rmpp_pkg.sv
// Package for the ramp memory-pressure policy block.
// Widths, codes, controller/datapath command types. No dependencies.
`default_nettype none
package rmpp_pkg;

  localparam int MEM_W   = 48;
  localparam int FAC_W   = 12;
  localparam int TO_W    = 14;
  localparam int PROD_W  = MEM_W + FAC_W;
  localparam int DVD_W   = MEM_W + 8;
  localparam int CNT_W   = $clog2(DVD_W);
  localparam int MAX_RETRY = 10000;

  localparam logic [MEM_W-1:0] MEM_MAX   = {MEM_W{1'b1}};
  localparam logic [MEM_W-1:0] BASE_RST  = MEM_W'(1000000);
  localparam logic [FAC_W-1:0] YF_RST    = FAC_W'(384);
  localparam logic [FAC_W-1:0] RF_RST    = FAC_W'(512);
  localparam logic [FAC_W-1:0] FAC_ONE   = FAC_W'(256);

  localparam logic [10:0] TICK_TO   = 11'd200;
  localparam logic [10:0] RED_TO    = 11'd250;
  localparam logic [10:0] YELLOW_TO = 11'd500;
  localparam logic [10:0] GREEN_TO  = 11'd1000;

  typedef enum logic [2:0] {
    REQ_APPLY  = 3'd0,
    REQ_THRESH = 3'd1,
    REQ_SWEEP  = 3'd2,
    REQ_TIMER  = 3'd3,
    REQ_CHECK  = 3'd4,
    REQ_SET    = 3'd5
  } req_t;

  typedef enum logic [1:0] {
    ST_GREEN  = 2'd0,
    ST_YELLOW = 2'd1,
    ST_RED    = 2'd2,
    ST_KEEP   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CFG_BASE = 2'd0,
    CFG_YF   = 2'd1,
    CFG_RF   = 2'd2
  } cfg_idx_t;

  // Where the memory amount sits relative to the levels before the event.
  typedef enum logic [1:0] {
    CLS_RED, CLS_YEL, CLS_RAMP, CLS_LOW
  } cls_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_MY, S_WY, S_WR, S_WTMP, S_DIV, S_LIM, S_FIN
  } state_t;

  typedef enum logic [1:0] { LIM_NONE, LIM_BASE, LIM_MAXMEM, LIM_DIVQ } lim_sel_t;
  typedef enum logic { SRC_LIMIT, SRC_RED } mul_src_t;
  typedef enum logic [1:0] { FAC_YF, FAC_RF, FAC_RFC } mul_fac_t;

  typedef struct packed {
    logic     latch;
    logic     cls;
    lim_sel_t lim;
    logic     mul_go;
    mul_src_t src;
    mul_fac_t fac;
    logic     wr_yl;
    logic     wr_rl;
    logic     wr_tmp;
    logic     div_go;
    logic     div_step;
    logic     fin;
  } cmd_t;

  typedef struct packed {
    logic [2:0] req;
    cls_t       cls;
    logic       sweep_low;
    logic       rf_lt_one;
    logic       div_last;
  } sts_t;

  typedef struct packed {
    logic [1:0]       status;
    logic             thv;
    logic [MEM_W-1:0] th;
    logic             tv;
    logic [TO_W-1:0]  to;
    logic             sug;
    logic             chk;
  } res_t;

  // base_ms * f / 256, truncated
  function automatic logic [TO_W-1:0] scale_to(input logic [10:0] b,
                                               input logic [FAC_W-1:0] f);
    logic [22:0] p;
    p = 23'(b) * 23'(f);
    return p[TO_W+7:8];
  endfunction

endpackage
`default_nettype wire

>>> design/rmpp_in_if.sv
// Input channel interface: valid/ready with event payload.
// Depends on rmpp_pkg.
`default_nettype none
interface rmpp_in_if import rmpp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [2:0]       req_type;
  logic [MEM_W-1:0] memory_amount;
  logic [MEM_W-1:0] freed_amount;
  logic [MEM_W-1:0] active_amount;
  modport source(output valid, req_type, memory_amount, freed_amount, active_amount,
                 input ready);
  modport sink(input valid, req_type, memory_amount, freed_amount, active_amount,
               output ready);
endinterface
`default_nettype wire

>>> design/rmpp_out_if.sv
// Result channel interface: valid/ready with policy result payload.
// Depends on rmpp_pkg.
`default_nettype none
interface rmpp_out_if import rmpp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic             threshold_valid;
  logic [MEM_W-1:0] next_threshold;
  logic             timeout_valid;
  logic [TO_W-1:0]  retry_timeout;
  logic             gc_suggest;
  logic             check_done;
  modport source(output valid, status, threshold_valid, next_threshold, timeout_valid,
                 retry_timeout, gc_suggest, check_done, input ready);
  modport sink(input valid, status, threshold_valid, next_threshold, timeout_valid,
               retry_timeout, gc_suggest, check_done, output ready);
endinterface
`default_nettype wire

>>> design/rmpp_cfg_if.sv
// Configuration write channel: valid/ready, register index and data.
// Depends on rmpp_pkg.
`default_nettype none
interface rmpp_cfg_if import rmpp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       index;
  logic [MEM_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> design/ramp_memory_pressure_policy_core.sv
// Top level of the ramp memory-pressure policy block.
// Depends on rmpp_pkg, rmpp_in_if, rmpp_out_if, rmpp_cfg_if, rmpp_ctrl, rmpp_dp.
//
// Handles one event item at a time and returns exactly one result item for it.
// Apply, sweep done and set limit run two 48x12 multiplies for the yellow and
// red levels, one more on a sweep when red_factor < 1.0 and the memory amount
// is above base; threshold crossed runs one only in red. A timer event that
// ramps the limit down runs a bit-serial divider, one quotient bit per cycle
// over 56 bits, then the level multiplies. The result sits in an output
// register, so a new item is taken once the previous one has been placed
// there, even if the sink has not yet taken it. Configuration writes are
// always accepted and are meant for idle periods only.
`default_nettype none
module ramp_memory_pressure_policy_core import rmpp_pkg::*; (
  input wire logic   clk,
  input wire logic   rst_n,
  rmpp_in_if.sink    in_ch,
  rmpp_out_if.source out_ch,
  rmpp_cfg_if.sink   cfg_ch
);

  cmd_t cmd;
  sts_t sts;
  res_t res;
  logic idle;
  logic in_fire;
  logic out_free;
  logic out_valid_r;
  res_t out_r;

  assign in_ch.ready  = idle;
  assign in_fire      = in_ch.valid && idle;
  assign out_free     = !out_valid_r || out_ch.ready;
  assign cfg_ch.ready = 1'b1;

  rmpp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .out_free (out_free),
    .sts      (sts),
    .idle     (idle),
    .cmd      (cmd)
  );

  rmpp_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cfg_we    (cfg_ch.valid),
    .cfg_idx   (cfg_ch.index),
    .cfg_data  (cfg_ch.data),
    .in_req    (in_ch.req_type),
    .in_mem    (in_ch.memory_amount),
    .in_freed  (in_ch.freed_amount),
    .in_active (in_ch.active_amount),
    .sts       (sts),
    .res       (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.fin) out_valid_r <= 1'b1;
    else if (out_ch.ready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) out_r <= res;
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.status          = out_r.status;
  assign out_ch.threshold_valid = out_r.thv;
  assign out_ch.next_threshold  = out_r.th;
  assign out_ch.timeout_valid   = out_r.tv;
  assign out_ch.retry_timeout   = out_r.to;
  assign out_ch.gc_suggest      = out_r.sug;
  assign out_ch.check_done      = out_r.chk;

endmodule
`default_nettype wire

>>> design/rmpp_ctrl.sv
// Controller FSM: sequences multiplies, the divider and result issue.
// Depends on rmpp_pkg.
`default_nettype none
module rmpp_ctrl import rmpp_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_fire,
  input  wire logic out_free,
  input  wire sts_t sts,
  output logic      idle,
  output cmd_t      cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    idle = 1'b0;
    case (state_r)
      S_IDLE: begin
        idle = 1'b1;
        if (in_fire) begin
          cmd.latch = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        cmd.cls = 1'b1;
        state_nxt = S_FIN;
        case (sts.req)
          REQ_APPLY: begin
            cmd.lim = LIM_BASE;
            state_nxt = S_MY;
          end
          REQ_SWEEP, REQ_SET: begin
            cmd.lim = LIM_MAXMEM;
            state_nxt = S_MY;
          end
          REQ_THRESH: begin
            if (sts.cls == CLS_RED) begin
              cmd.mul_go = 1'b1;
              cmd.src = SRC_RED;
              cmd.fac = FAC_RF;
              state_nxt = S_WTMP;
            end
          end
          REQ_TIMER: begin
            if (sts.cls == CLS_RAMP) begin
              cmd.div_go = 1'b1;
              state_nxt = S_DIV;
            end
          end
          default: state_nxt = S_FIN;
        endcase
      end
      S_MY: begin
        cmd.mul_go = 1'b1;
        cmd.src = SRC_LIMIT;
        cmd.fac = FAC_YF;
        state_nxt = S_WY;
      end
      S_WY: begin
        cmd.wr_yl = 1'b1;
        cmd.mul_go = 1'b1;
        cmd.src = SRC_LIMIT;
        cmd.fac = FAC_RF;
        state_nxt = S_WR;
      end
      S_WR: begin
        cmd.wr_rl = 1'b1;
        state_nxt = S_FIN;
        if (sts.req == REQ_SWEEP && !sts.sweep_low && sts.rf_lt_one) begin
          cmd.mul_go = 1'b1;
          cmd.src = SRC_LIMIT;
          cmd.fac = FAC_RFC;
          state_nxt = S_WTMP;
        end
      end
      S_WTMP: begin
        cmd.wr_tmp = 1'b1;
        state_nxt = S_FIN;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = S_LIM;
      end
      S_LIM: begin
        cmd.lim = LIM_DIVQ;
        state_nxt = S_MY;
      end
      S_FIN: begin
        if (out_free) begin
          cmd.fin = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

>>> design/rmpp_dp.sv
// Datapath: config registers, limit/levels, multiplier, bit-serial divider,
// result formation. Depends on rmpp_pkg.
`default_nettype none
module rmpp_dp import rmpp_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire cmd_t             cmd,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_idx,
  input  wire logic [MEM_W-1:0] cfg_data,
  input  wire logic [2:0]       in_req,
  input  wire logic [MEM_W-1:0] in_mem,
  input  wire logic [MEM_W-1:0] in_freed,
  input  wire logic [MEM_W-1:0] in_active,
  output sts_t                  sts,
  output res_t                  res
);

  logic [MEM_W-1:0]  base_r;
  logic [FAC_W-1:0]  yf_r, rf_r;
  logic [MEM_W-1:0]  lim_r, lim_nxt, yl_r, rl_r, tmp_r;
  logic [TO_W-1:0]   rt_r, rt_nxt;
  logic [2:0]        req_r;
  logic [MEM_W-1:0]  mem_r, freed_r, active_r;
  cls_t              cls_r, cls_now;
  logic [PROD_W-1:0] prod_r;
  logic [MEM_W-1:0]  prod_sat;
  logic [MEM_W-1:0]  mul_a;
  logic [FAC_W-1:0]  mul_f;
  logic [DVD_W-1:0]  dvd_r;
  logic [FAC_W-1:0]  rem_r;
  logic [FAC_W:0]    dtry;
  logic              qbit;
  logic [CNT_W-1:0]  cnt_r;
  logic [MEM_W-1:0]  divq;
  logic [MEM_W:0]    chk_sum;
  logic [TO_W:0]     tsum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= BASE_RST;
      yf_r   <= YF_RST;
      rf_r   <= RF_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_BASE: base_r <= cfg_data;
        CFG_YF:   yf_r   <= cfg_data[FAC_W-1:0];
        CFG_RF:   rf_r   <= cfg_data[FAC_W-1:0];
        default: ;
      endcase
    end
  end

  // pre-event position of the memory amount
  always_comb begin
    if (mem_r >= rl_r)        cls_now = CLS_RED;
    else if (mem_r >= yl_r)   cls_now = CLS_YEL;
    else if (mem_r >= base_r) cls_now = CLS_RAMP;
    else                      cls_now = CLS_LOW;
  end

  // multiplier operands; product registered, truncated and saturated on use
  always_comb begin
    mul_a = (cmd.src == SRC_RED) ? rl_r : lim_r;
    case (cmd.fac)
      FAC_YF:  mul_f = yf_r;
      FAC_RF:  mul_f = rf_r;
      FAC_RFC: mul_f = FAC_ONE - rf_r;
      default: mul_f = rf_r;
    endcase
  end
  assign prod_sat = (|prod_r[PROD_W-1:MEM_W+8]) ? MEM_MAX : prod_r[MEM_W+7:8];

  // restoring divider: (limit << 8) / yf, one quotient bit per cycle
  assign dtry = {rem_r, dvd_r[DVD_W-1]};
  assign qbit = dtry >= {1'b0, yf_r};
  assign divq = (|dvd_r[DVD_W-1:MEM_W]) ? MEM_MAX : dvd_r[MEM_W-1:0];

  always_comb begin
    case (cmd.lim)
      LIM_BASE:   lim_nxt = base_r;
      LIM_MAXMEM: lim_nxt = (mem_r < base_r) ? base_r : mem_r;
      LIM_DIVQ:   lim_nxt = (divq < base_r) ? base_r : divq;
      default:    lim_nxt = lim_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r <= '0;
      yl_r  <= '0;
      rl_r  <= '0;
      rt_r  <= '0;
    end else begin
      lim_r <= lim_nxt;
      if (cmd.wr_yl) yl_r <= prod_sat;
      if (cmd.wr_rl) rl_r <= prod_sat;
      if (cmd.fin)   rt_r <= rt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_r    <= in_req;
      mem_r    <= in_mem;
      freed_r  <= in_freed;
      active_r <= in_active;
    end
    if (cmd.cls)    cls_r  <= cls_now;
    if (cmd.mul_go) prod_r <= PROD_W'(mul_a) * PROD_W'(mul_f);
    if (cmd.wr_tmp) tmp_r  <= prod_sat;
    if (cmd.div_go) begin
      dvd_r <= {lim_r, 8'd0};
      rem_r <= '0;
      cnt_r <= CNT_W'(DVD_W - 1);
    end else if (cmd.div_step) begin
      dvd_r <= {dvd_r[DVD_W-2:0], qbit};
      rem_r <= qbit ? FAC_W'(dtry - {1'b0, yf_r}) : dtry[FAC_W-1:0];
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign sts.req       = req_r;
  assign sts.cls       = cls_now;
  assign sts.sweep_low = mem_r <= base_r;
  assign sts.rf_lt_one = rf_r < FAC_ONE;
  assign sts.div_last  = cnt_r == '0;

  assign chk_sum = {1'b0, active_r} + {1'b0, rl_r};

  always_comb begin
    res    = '0;
    res.status = ST_KEEP;
    rt_nxt = rt_r;
    tsum   = '0;
    case (req_r)
      REQ_APPLY: begin
        res.thv = 1'b1;
        res.th  = yl_r;
      end
      REQ_THRESH: begin
        res.thv = 1'b1;
        res.tv  = 1'b1;
        if (cls_r == CLS_RED) begin
          res.status = ST_RED;
          res.sug = 1'b1;
          res.th  = tmp_r;
          rt_nxt  = scale_to(RED_TO, yf_r);
        end else if (cls_r == CLS_YEL) begin
          res.status = ST_YELLOW;
          res.sug = 1'b1;
          res.th  = rl_r;
          rt_nxt  = scale_to(YELLOW_TO, yf_r);
        end else begin
          res.th  = yl_r;
          rt_nxt  = scale_to(GREEN_TO, yf_r);
        end
        res.to = rt_nxt;
      end
      REQ_SWEEP: begin
        res.thv = 1'b1;
        res.th  = yl_r;
        if (mem_r <= base_r) begin
          res.status = ST_GREEN;
          res.tv = 1'b1;
        end else if (rf_r >= FAC_ONE || freed_r >= tmp_r) begin
          rt_nxt = TO_W'(TICK_TO);
          res.tv = 1'b1;
          res.to = TO_W'(TICK_TO);
        end
      end
      REQ_TIMER: begin
        case (cls_r)
          CLS_RED: begin
            res.status = ST_RED;
            res.sug = 1'b1;
            tsum = {1'b0, rt_r} + {1'b0, scale_to(RED_TO, rf_r)};
          end
          CLS_YEL: begin
            res.status = ST_YELLOW;
            res.sug = 1'b1;
            tsum = {1'b0, rt_r} + {1'b0, scale_to(YELLOW_TO, rf_r)};
          end
          CLS_RAMP: begin
            // levels already recomputed from the lowered limit
            if (mem_r >= rl_r) begin
              res.status = ST_RED;
              tsum = {1'b0, rt_r} + {1'b0, scale_to(YELLOW_TO, rf_r)};
            end else if (mem_r >= yl_r) begin
              res.status = ST_YELLOW;
              tsum = {1'b0, rt_r} + {1'b0, scale_to(YELLOW_TO, rf_r)};
            end else begin
              res.status = ST_GREEN;
              tsum = {1'b0, rt_r} + {1'b0, scale_to(GREEN_TO, rf_r)};
            end
            res.thv = yl_r != '0;
            res.th  = (yl_r != '0) ? yl_r : '0;
          end
          default: begin
            res.status = ST_GREEN;
            res.thv = 1'b1;
            res.th  = yl_r;
          end
        endcase
        rt_nxt = (tsum > (TO_W+1)'(MAX_RETRY)) ? TO_W'(MAX_RETRY) : tsum[TO_W-1:0];
        res.tv = 1'b1;
        res.to = rt_nxt;
      end
      REQ_CHECK: res.chk = chk_sum < {1'b0, mem_r};
      default: ;
    endcase
  end

endmodule
`default_nettype wire

>>> design/rmpp_chk.sv
// Port-level checker for the policy core, bound to the top level.
// Depends on rmpp_pkg.
`default_nettype none
module rmpp_chk import rmpp_pkg::*; (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_valid,
  input wire logic             in_ready,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic [1:0]       status,
  input wire logic             threshold_valid,
  input wire logic [MEM_W-1:0] next_threshold,
  input wire logic             timeout_valid,
  input wire logic [TO_W-1:0]  retry_timeout,
  input wire logic             check_done
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("item taken while busy");

  a_th_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !threshold_valid |-> next_threshold == '0)
    else $error("threshold not cleared");

  a_to_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !timeout_valid |-> retry_timeout == '0)
    else $error("timeout not cleared");

  a_chk_keep: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && check_done |-> status == ST_KEEP && !threshold_valid)
    else $error("check result with status");

endmodule

bind ramp_memory_pressure_policy_core rmpp_chk u_rmpp_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .status          (out_ch.status),
  .threshold_valid (out_ch.threshold_valid),
  .next_threshold  (out_ch.next_threshold),
  .timeout_valid   (out_ch.timeout_valid),
  .retry_timeout   (out_ch.retry_timeout),
  .check_done      (out_ch.check_done)
);
`default_nettype wire
